// File: rtl/asid_pkg.sv
// Package for the array search/insert/delete block.
// Holds sizes, action and status codes and the memory request struct.
// No dependencies.
package asid_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int PW    = 7;

  typedef enum logic [1:0] {
    ACT_LIN = 2'd0,
    ACT_BIN = 2'd1,
    ACT_INS = 2'd2,
    ACT_DEL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

// File: rtl/asid_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on asid_pkg.
interface asid_in_if import asid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [PW-1:0]        position;
  logic signed [DW-1:0] key_value;

  modport source (output valid, output action, output position, output key_value,
                  input ready);
  modport sink (input valid, input action, input position, input key_value,
                output ready);
endinterface

interface asid_out_if import asid_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [AW-1:0] found_index;
  logic [CW-1:0] entry_count;

  modport source (output valid, output status, output found_index, output entry_count,
                  input ready);
  modport sink (input valid, input status, input found_index, input entry_count,
                output ready);
endinterface

// File: rtl/asid_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module asid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/asid_ctrl.sv
// Sequencer: runs searches and shifts through the entry memory, keeps the count
// and holds the result item. Depends on asid_pkg and asid_if.
module asid_ctrl import asid_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  asid_in_if.sink        in_ch,
  asid_out_if.source     out_ch,
  output mem_req_t       mreq,
  input  logic [DW-1:0]  mem_rdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LIN  = 7'b0000010,
    S_BRD  = 7'b0000100,
    S_BCMP = 7'b0001000,
    S_SHUP = 7'b0010000,
    S_INSW = 7'b0100000,
    S_SHDN = 7'b1000000
  } state_t;

  localparam state_t S_RESP_UNUSED = S_IDLE;

  state_t               state_r, state_nxt;
  logic                 resp_r, resp_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]        chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        mid_r, mid_nxt;
  logic [CW-1:0]        pos_m1_r, pos_m1_nxt;
  logic signed [DW-1:0] key_r, key_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [AW-1:0]        res_idx_r, res_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [AW-1:0]        out_idx_r, out_idx_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;

  logic                 accept;
  logic                 hit;
  logic                 below;
  logic [CW-1:0]        rd_dec;
  logic [CW-1:0]        rd_inc;
  logic [CW-1:0]        mid_calc;
  logic [CW-1:0]        pos_ext;

  assign in_ch.ready        = (state_r == S_IDLE) && !resp_r;
  assign accept             = in_ch.valid && in_ch.ready;
  assign hit                = (mem_rdata == key_r);
  assign below              = ($signed(mem_rdata) < key_r);
  assign rd_dec             = rd_ptr_r - 1'b1;
  assign rd_inc             = rd_ptr_r + 1'b1;
  assign mid_calc           = lo_r + ((hi_r - 1'b1 - lo_r) >> 1);
  assign pos_ext            = CW'(in_ch.position);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_idx_r;
  assign out_ch.entry_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    resp_nxt       = resp_r;
    count_nxt      = count_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    rd_ptr_nxt     = rd_ptr_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    pos_m1_nxt     = pos_m1_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_count_nxt  = out_count_r;
    mreq           = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // hand the finished item to the output register
    if (resp_r && (!out_valid_r || out_ch.ready)) begin
      resp_nxt       = 1'b0;
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_idx_nxt    = res_idx_r;
      out_count_nxt  = count_r;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt        = in_ch.key_value;
          res_status_nxt = ST_OK;
          res_idx_nxt    = '0;
          chk_vld_nxt    = 1'b0;
          pos_m1_nxt     = pos_ext - 1'b1;
          case (action_t'(in_ch.action))
            ACT_LIN: begin
              rd_ptr_nxt = '0;
              state_nxt  = S_LIN;
            end
            ACT_BIN: begin
              lo_nxt    = '0;
              hi_nxt    = count_r;
              state_nxt = S_BRD;
            end
            ACT_INS: begin
              if (count_r == CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
                resp_nxt       = 1'b1;
              end else if (pos_ext == '0 || pos_ext > count_r + 1'b1) begin
                res_status_nxt = ST_BADPOS;
                resp_nxt       = 1'b1;
              end else begin
                rd_ptr_nxt = count_r;
                state_nxt  = S_SHUP;
              end
            end
            ACT_DEL: begin
              if (pos_ext == '0 || pos_ext > count_r) begin
                res_status_nxt = ST_BADPOS;
                resp_nxt       = 1'b1;
              end else begin
                rd_ptr_nxt = pos_ext;
                state_nxt  = S_SHDN;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LIN: begin
        if (chk_vld_r && hit) begin
          res_idx_nxt = chk_idx_r;
          chk_vld_nxt = 1'b0;
          resp_nxt    = 1'b1;
          state_nxt   = S_IDLE;
        end else if (rd_ptr_r == count_r) begin
          res_status_nxt = ST_MISS;
          chk_vld_nxt    = 1'b0;
          resp_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          mreq.raddr  = rd_ptr_r[AW-1:0];
          chk_idx_nxt = rd_ptr_r[AW-1:0];
          chk_vld_nxt = 1'b1;
          rd_ptr_nxt  = rd_inc;
        end
      end
      S_BRD: begin
        if (lo_r < hi_r) begin
          mreq.raddr = mid_calc[AW-1:0];
          mid_nxt    = mid_calc;
          state_nxt  = S_BCMP;
        end else begin
          res_status_nxt = ST_MISS;
          resp_nxt       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_BCMP: begin
        if (hit) begin
          res_idx_nxt = mid_r[AW-1:0];
          resp_nxt    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          if (below) begin
            lo_nxt = mid_r + 1'b1;
          end else begin
            hi_nxt = mid_r;
          end
          state_nxt = S_BRD;
        end
      end
      S_SHUP: begin
        if (chk_vld_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = chk_idx_r + 1'b1;
          mreq.wdata = mem_rdata;
        end
        if (rd_ptr_r > pos_m1_r) begin
          mreq.raddr  = rd_dec[AW-1:0];
          chk_idx_nxt = rd_dec[AW-1:0];
          chk_vld_nxt = 1'b1;
          rd_ptr_nxt  = rd_dec;
        end else begin
          chk_vld_nxt = 1'b0;
          state_nxt   = S_INSW;
        end
      end
      S_INSW: begin
        mreq.we    = 1'b1;
        mreq.waddr = pos_m1_r[AW-1:0];
        mreq.wdata = key_r;
        count_nxt  = count_r + 1'b1;
        resp_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SHDN: begin
        if (chk_vld_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = chk_idx_r - 1'b1;
          mreq.wdata = mem_rdata;
        end
        if (rd_ptr_r < count_r) begin
          mreq.raddr  = rd_ptr_r[AW-1:0];
          chk_idx_nxt = rd_ptr_r[AW-1:0];
          chk_vld_nxt = 1'b1;
          rd_ptr_nxt  = rd_inc;
        end else begin
          chk_vld_nxt = 1'b0;
          count_nxt   = count_r - 1'b1;
          resp_nxt    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_RESP_UNUSED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      resp_r      <= 1'b0;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resp_r      <= resp_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    pos_m1_r     <= pos_m1_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

// File: rtl/array_search_insert_delete_top.sv
// Ordered entry store with linear/binary search, positional insert and delete.
// One item at a time; the entry memory (one read, one write per cycle) sets the pace.
// A finished item waits in the output register while the next one is accepted.
// Reset (rst_n, synchronous, active low) empties the store; entries are not cleared.
module array_search_insert_delete_top import asid_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  asid_in_if.sink     in_ch,
  asid_out_if.source  out_ch
);

  mem_req_t      mreq;
  logic [DW-1:0] mem_rdata;

  asid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mreq      (mreq),
    .mem_rdata (mem_rdata)
  );

  asid_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .raddr (mreq.raddr),
    .rdata (mem_rdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while previous item still at work");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.we |-> !in_ch.ready)
    else $error("memory written while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.entry_count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.found_index == '0)
    else $error("nonzero index on failed item");

endmodule

// File: bench/asid_result_checker.sv
// Result checker for array_search_insert_delete_top: watches both channels,
// predicts each result from its own copy of the store and compares field by field.
// Depends on asid_pkg and the channel interfaces in asid_if.sv.
module asid_result_checker import asid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  asid_in_if   in_ch,
  asid_out_if  out_ch,
  output int   fail_count,
  output int   open_count
);

  typedef struct packed {
    status_t       status;
    logic [AW-1:0] index;
    logic [CW-1:0] count;
  } answer_t;

  logic signed [DW-1:0] shelf [DEPTH];
  int                   held;
  answer_t              due_results [$];

  initial begin
    fail_count = 0;
    open_count = 0;
    held       = 0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic answer_t apply_request(action_t act, logic [PW-1:0] slot,
                                            logic signed [DW-1:0] key);
    answer_t r;
    int      p;
    int      i;
    int      lo;
    int      hi;
    int      mid;
    bit      hit;
    r.status = ST_OK;
    r.index  = '0;
    p        = int'(slot);
    hit      = 1'b0;
    case (act)
      ACT_LIN: begin
        for (i = 0; i < held && !hit; i++) begin
          if (shelf[i] == key) begin
            hit     = 1'b1;
            r.index = AW'(i);
          end
        end
        if (!hit) r.status = ST_MISS;
      end
      ACT_BIN: begin
        lo = 0;
        hi = held - 1;
        while (lo <= hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          if (shelf[mid] == key) begin
            hit     = 1'b1;
            r.index = AW'(mid);
          end else if (shelf[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (!hit) r.status = ST_MISS;
      end
      ACT_INS: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > held + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = held; i > p - 1; i--) shelf[i] = shelf[i - 1];
          shelf[p - 1] = key;
          held++;
        end
      end
      default: begin
        if (p < 1 || p > held) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < held; i++) shelf[i] = shelf[i + 1];
          held--;
        end
      end
    endcase
    r.count = CW'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      held = 0;
      due_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", int'(out_ch.status), -1);
        end else begin
          want = due_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", int'(out_ch.status), int'(want.status));
          if (out_ch.found_index !== want.index)
            report_mismatch("found_index", int'(out_ch.found_index), int'(want.index));
          if (out_ch.entry_count !== want.count)
            report_mismatch("entry_count", int'(out_ch.entry_count), int'(want.count));
        end
      end
      if (in_ch.valid && in_ch.ready)
        due_results.push_back(apply_request(action_t'(in_ch.action), in_ch.position,
                                            in_ch.key_value));
    end
    open_count <= due_results.size();
  end

endmodule

// File: bench/tb.sv
// Testbench top for array_search_insert_delete_top: clock, reset, request stimulus
// (directed, then fill, drain, sorted-search and noise rounds), receiver stalls, verdict.
// Depends on asid_pkg, asid_if.sv, the block and asid_result_checker.
module tb import asid_pkg::*;;

  localparam logic signed [DW-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   open_count;

  int                   sent;
  int                   fill;
  int                   burst_left;
  logic signed [DW-1:0] seen_keys [$];
  logic signed [DW-1:0] ladder [$];

  asid_in_if  in_ch ();
  asid_out_if out_ch ();

  array_search_insert_delete_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  asid_result_checker result_watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("array_search_insert_delete_top verification failed");
    $finish;
  end

  function automatic logic signed [DW-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: pick_key = KEY_MIN;
      1: pick_key = KEY_MAX;
      2: pick_key = ($urandom_range(0, 1) == 1) ? 32'sd0 : -32'sd1;
      3, 4: pick_key = int'($urandom_range(0, 16)) - 8;
      default: pick_key = $urandom;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_search_key();
    if (seen_keys.size() > 0 && $urandom_range(0, 1) == 1)
      pick_search_key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    else
      pick_search_key = pick_key();
  endfunction

  function automatic action_t pick_search();
    pick_search = action_t'($urandom_range(0, 1));
  endfunction

  function automatic int bad_slot(int first_bad);
    bad_slot = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(first_bad, 127));
  endfunction

  task automatic send_request(action_t act, int slot, logic signed [DW-1:0] key);
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.position  <= slot[PW-1:0];
    in_ch.key_value <= key;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (act == ACT_INS && fill < DEPTH && slot >= 1 && slot <= fill + 1) begin
      fill++;
      seen_keys.push_back(key);
      if (seen_keys.size() > DEPTH) void'(seen_keys.pop_front());
    end else if (act == ACT_DEL && slot >= 1 && slot <= fill) begin
      fill--;
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  task automatic fill_round();
    int roll;
    while (fill < DEPTH) begin
      roll = $urandom_range(0, 9);
      if (roll < 7)
        send_request(ACT_INS, $urandom_range(1, fill + 1), pick_key());
      else if (roll == 7)
        send_request(pick_search(), $urandom_range(0, 127), pick_search_key());
      else if (roll == 8 && fill > 0)
        send_request(ACT_DEL, $urandom_range(1, fill), pick_key());
      else
        send_request(ACT_INS, bad_slot(fill + 2), pick_key());
    end
    repeat (3) send_request(ACT_INS, $urandom_range(0, 127), pick_key());
  endtask

  task automatic drain_round();
    int roll;
    while (fill > 0) begin
      roll = $urandom_range(0, 19);
      if (roll < 14)
        send_request(ACT_DEL, $urandom_range(1, fill), pick_key());
      else if (roll < 17)
        send_request(pick_search(), $urandom_range(0, 127), pick_search_key());
      else
        send_request(ACT_DEL, bad_slot(fill + 1), pick_key());
    end
    send_request(ACT_DEL, $urandom_range(0, 127), pick_key());
  endtask

  task automatic sorted_round();
    int                   n;
    logic signed [DW-1:0] k;
    logic signed [DW-1:0] probe;
    while (fill > 0) send_request(ACT_DEL, fill, pick_key());
    ladder.delete();
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 8) : $urandom_range(9, DEPTH);
    k = int'($urandom_range(0, 32'h3fff_ffff)) - 32'sh4000_0000;
    repeat (n) begin
      ladder.push_back(k);
      send_request(ACT_INS, fill + 1, k);
      if ($urandom_range(0, 4) != 0) k = k + int'($urandom_range(1, 1 << 24));
    end
    repeat (2 * n) begin
      probe = ladder[$urandom_range(0, ladder.size() - 1)];
      case ($urandom_range(0, 5))
        0: probe = probe + 1;
        1: probe = probe - 1;
        2: probe = ($urandom_range(0, 1) == 1) ? KEY_MIN : KEY_MAX;
        default: ;
      endcase
      send_request(($urandom_range(0, 3) == 0) ? ACT_LIN : ACT_BIN,
                   $urandom_range(0, 127), probe);
    end
  endtask

  task automatic noise_round();
    repeat (40)
      send_request(action_t'($urandom_range(0, 3)), $urandom_range(0, 127), pick_search_key());
  endtask

  initial begin : receiver
    int seg;
    int mode;
    int span;
    seg = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      seg++;
      if (seg == 6) begin
        out_ch.ready <= 1'b0;
        repeat (500) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 200);
        repeat (span) begin
          case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            default: out_ch.ready <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    sent       = 0;
    fill       = 0;
    burst_left = 6;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_LIN;
    in_ch.position  <= '0;
    in_ch.key_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ACT_LIN, 0, 32'sd0);
    send_request(ACT_BIN, 0, 32'sd0);
    send_request(ACT_DEL, 1, 32'sd0);
    send_request(ACT_DEL, 0, KEY_MAX);
    send_request(ACT_INS, 0, 32'sd5);
    send_request(ACT_INS, 2, 32'sd5);
    send_request(ACT_INS, 1, KEY_MIN);
    send_request(ACT_INS, 2, KEY_MAX);
    send_request(ACT_INS, 2, 32'sd0);
    send_request(ACT_INS, 4, 32'sd0);
    send_request(ACT_LIN, 0, 32'sd0);
    send_request(ACT_LIN, 127, KEY_MAX);
    send_request(ACT_BIN, 0, KEY_MIN);
    send_request(ACT_BIN, 0, -32'sd1);
    send_request(ACT_LIN, 0, 32'sh5555_5555);
    send_request(ACT_INS, 6, 32'sd1);
    send_request(ACT_INS, 127, 32'sd1);
    send_request(ACT_DEL, 5, 32'sd0);
    send_request(ACT_DEL, 127, 32'sd0);
    send_request(ACT_DEL, 4, 32'sd0);
    send_request(ACT_DEL, 1, 32'sd0);
    send_request(ACT_INS, 65, -32'sd1);
    send_request(ACT_BIN, 0, KEY_MAX);
    send_request(ACT_DEL, 2, 32'sd0);
    send_request(ACT_DEL, 1, 32'sd0);

    while (sent < 1100) begin
      case ($urandom_range(0, 3))
        0: fill_round();
        1: drain_round();
        2: sorted_round();
        default: noise_round();
      endcase
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0)
      $display("array_search_insert_delete_top verification clean");
    else
      $display("array_search_insert_delete_top verification failed");
    $finish;
  end

endmodule
